@@ rtl/core/c8eu_pkg.sv @@
// ----------------------------------------------------------------------------
// c8eu_pkg
// types, constants and the hex font for the chip-8 execute unit
// ----------------------------------------------------------------------------
`default_nettype none
package c8eu_pkg;

	localparam int MEMORY_BYTES_DEF  = 4096;
	localparam int STACK_ENTRIES_DEF = 16;
	localparam int SCREEN_ROWS       = 32;
	localparam int GLYPH_HEIGHT      = 5;
	localparam int FONT_BYTES        = 80;

	localparam logic [1:0] KIND_EXEC  = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_OVER  = 2'd1;
	localparam logic [1:0] ERR_UNDER = 2'd2;
	localparam logic [1:0] ERR_UNK   = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] opcode;
		logic [11:0] load_address;
		logic [7:0]  load_byte;
		logic [15:0] keys_down;
		logic [7:0]  random_byte;
	} req_t;

	typedef struct packed {
		logic        has_row;
		logic [4:0]  row_index;
		logic [63:0] row_pixels;
		logic [11:0] program_counter;
		logic [11:0] index_value;
		logic        sound_on;
		logic        waiting_key;
		logic [1:0]  error_code;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DEC, ST_CLR_RD, ST_CLR_CHK, ST_MEM_RD, ST_MEM_WR,
		ST_DRAW_RD, ST_DRAW_WR, ST_EMIT, ST_CLR_EMIT, ST_FIN, ST_FILL
	} state_t;

	function automatic logic [7:0] font_byte(input logic [6:0] a);
		logic [7:0] f [FONT_BYTES];
		f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
		      8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
		      8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
		      8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
		      8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
		      8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
		      8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
		      8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
		if (a < 7'(FONT_BYTES))
			return f[a];
		return 8'h00;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/c8eu_mem.sv @@
// ----------------------------------------------------------------------------
// c8eu_mem
// byte memory, single port, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module c8eu_mem #(
	parameter int MEMORY_BYTES = c8eu_pkg::MEMORY_BYTES_DEF,
	localparam int AW = $clog2(MEMORY_BYTES)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [7:0]    wdata,
	output logic      [7:0]    rdata
);
	logic [7:0] mem [MEMORY_BYTES];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

@@ rtl/core/c8eu_fb.sv @@
// ----------------------------------------------------------------------------
// c8eu_fb
// framebuffer row memory, single port, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module c8eu_fb (
	input  wire logic        clk,
	input  wire logic        we,
	input  wire logic [4:0]  addr,
	input  wire logic [63:0] wdata,
	output logic      [63:0] rdata
);
	logic [63:0] rows [c8eu_pkg::SCREEN_ROWS];

	always_ff @(posedge clk) begin
		if (we)
			rows[addr] <= wdata;
		rdata <= rows[addr];
	end
endmodule
`default_nettype wire

@@ rtl/core/chip8_instruction_execute_unit.sv @@
// ----------------------------------------------------------------------------
// chip8_instruction_execute_unit
// chip-8 opcode execution around byte memory and framebuffer row memory
// ----------------------------------------------------------------------------
// one request at a time; the next can be taken in the cycle after the last
//   result is accepted
// reset: after arst_n rises, a fill pass writes the font, zeroes memory and
//   clears the framebuffer; no request is taken until the pass ends
`default_nettype none
module chip8_instruction_execute_unit #(
	parameter int MEMORY_BYTES  = c8eu_pkg::MEMORY_BYTES_DEF,
	parameter int STACK_ENTRIES = c8eu_pkg::STACK_ENTRIES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire c8eu_pkg::req_t   in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output c8eu_pkg::rsp_t        out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [11:0]      cfg_data
);
	localparam int AW = $clog2(MEMORY_BYTES);
	localparam int SW = $clog2(STACK_ENTRIES);
	localparam int DW = $clog2(STACK_ENTRIES + 1);
	localparam int FW = $clog2(MEMORY_BYTES + 32);

	c8eu_pkg::state_t state_q, state_nx;
	c8eu_pkg::req_t   req_q;
	logic [11:0] start_q, pc_q, i_q;
	logic [7:0]  v_q [16];
	logic [11:0] stk_q [STACK_ENTRIES];
	logic [DW-1:0] sp_q;
	logic [7:0]  dt_q, st_q;
	logic [1:0]  err_q;
	logic        wait_q, hit_q;
	logic [4:0]  cnt_q;
	logic [5:0]  rows_q;
	logic [4:0]  rid_q [32];
	logic [FW-1:0] fill_q;
	logic [5:0]  x0_q;
	logic [4:0]  y0_q;

	logic          m_we, f_we;
	logic [AW-1:0] m_addr;
	logic [7:0]    m_wd, m_rd;
	logic [4:0]    f_addr;
	logic [63:0]   f_wd, f_rd;

	c8eu_mem #(.MEMORY_BYTES(MEMORY_BYTES)) u_mem (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));
	c8eu_fb u_fb (.clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));

	logic [3:0] op_hi, ox, oy, on;
	logic [7:0] kk, vx, vy;
	assign op_hi = req_q.opcode[15:12];
	assign ox = req_q.opcode[11:8];
	assign oy = req_q.opcode[7:4];
	assign on = req_q.opcode[3:0];
	assign kk = req_q.opcode[7:0];
	assign vx = v_q[ox];
	assign vy = v_q[oy];

	logic is_cls, is_blk, is_draw, is_bcd, blk_store;
	assign is_cls  = req_q.kind == c8eu_pkg::KIND_EXEC && req_q.opcode == 16'h00E0;
	assign is_draw = req_q.kind == c8eu_pkg::KIND_EXEC && op_hi == 4'hD;
	assign is_bcd  = req_q.kind == c8eu_pkg::KIND_EXEC && op_hi == 4'hF && kk == 8'h33;
	assign blk_store = op_hi == 4'hF && kk == 8'h55;
	assign is_blk  = req_q.kind == c8eu_pkg::KIND_EXEC &&
		(blk_store || (op_hi == 4'hF && kk == 8'h65));

	// bcd digits of vx
	logic [7:0] bcd_h, bcd_t, bcd_o, rem_h;
	always_comb begin
		bcd_h = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
		rem_h = vx - 8'(bcd_h * 8'd100);
		bcd_t = 8'((16'(rem_h) * 16'd205) >> 11);
		bcd_o = rem_h - 8'(bcd_t * 8'd10);
	end

	logic [4:0] mem_n;
	assign mem_n = is_bcd ? 5'd3 : (is_blk ? 5'(ox) + 5'd1 : 5'(on));

	logic [11:0] a12;
	assign a12 = i_q + 12'(cnt_q);

	// sprite row xor
	logic [63:0] smask, nrow;
	always_comb begin
		smask = 64'(m_rd) << 56;
		smask = (smask >> x0_q) | (smask << (7'd64 - 7'(x0_q)));
		nrow = f_rd ^ smask;
	end

	logic out_fire, last_row;
	assign out_fire = out_valid && !out_stall;
	assign last_row = 6'(cnt_q) + 6'd1 >= rows_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			c8eu_pkg::ST_FILL: if (32'(fill_q) == MEMORY_BYTES + 31) state_nx = c8eu_pkg::ST_IDLE;
			c8eu_pkg::ST_IDLE: if (in_valid) state_nx = c8eu_pkg::ST_DEC;
			c8eu_pkg::ST_DEC: begin
				if (is_cls) state_nx = c8eu_pkg::ST_CLR_RD;
				else if ((is_blk || is_bcd) && !blk_store && !is_bcd) state_nx = c8eu_pkg::ST_MEM_RD;
				else if (is_blk || is_bcd) state_nx = c8eu_pkg::ST_MEM_WR;
				else if (is_draw && on != 4'd0) state_nx = c8eu_pkg::ST_DRAW_RD;
				else state_nx = c8eu_pkg::ST_FIN;
			end
			c8eu_pkg::ST_MEM_RD: state_nx = c8eu_pkg::ST_MEM_WR;
			c8eu_pkg::ST_MEM_WR:
				if (cnt_q + 5'd1 >= mem_n) state_nx = c8eu_pkg::ST_FIN;
				else if (!blk_store && !is_bcd) state_nx = c8eu_pkg::ST_MEM_RD;
			c8eu_pkg::ST_DRAW_RD: state_nx = c8eu_pkg::ST_DRAW_WR;
			c8eu_pkg::ST_DRAW_WR:
				state_nx = (cnt_q + 5'd1 >= 5'(on)) ? c8eu_pkg::ST_FIN : c8eu_pkg::ST_DRAW_RD;
			c8eu_pkg::ST_CLR_RD: state_nx = c8eu_pkg::ST_CLR_CHK;
			c8eu_pkg::ST_CLR_CHK:
				state_nx = (cnt_q == 5'd31) ? c8eu_pkg::ST_FIN : c8eu_pkg::ST_CLR_RD;
			c8eu_pkg::ST_FIN: state_nx = c8eu_pkg::ST_EMIT;
			c8eu_pkg::ST_EMIT: state_nx = c8eu_pkg::ST_CLR_EMIT;
			c8eu_pkg::ST_CLR_EMIT:
				if (out_fire && (rows_q == 6'd0 || last_row)) state_nx = c8eu_pkg::ST_IDLE;
				else if (out_fire) state_nx = c8eu_pkg::ST_EMIT;
			default: state_nx = c8eu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		m_we = 1'b0;
		m_addr = AW'(a12);
		m_wd = 8'h00;
		f_we = 1'b0;
		f_addr = cnt_q;
		f_wd = 64'h0;
		case (state_q)
			c8eu_pkg::ST_FILL: begin
				m_we = 32'(fill_q) < MEMORY_BYTES;
				m_addr = AW'(fill_q);
				m_wd = c8eu_pkg::font_byte(7'(fill_q > FW'(127) ? FW'(127) : fill_q));
				f_we = 1'b1;
				f_addr = fill_q[4:0];
			end
			c8eu_pkg::ST_DEC: begin
				m_we = req_q.kind == c8eu_pkg::KIND_LOAD;
				m_addr = AW'(req_q.load_address);
				m_wd = req_q.load_byte;
			end
			c8eu_pkg::ST_MEM_WR: begin
				m_we = blk_store || is_bcd;
				m_wd = is_bcd ? (cnt_q == 5'd0 ? bcd_h : cnt_q == 5'd1 ? bcd_t : bcd_o)
					: v_q[cnt_q[3:0]];
			end
			c8eu_pkg::ST_DRAW_RD: f_addr = y0_q + cnt_q;
			c8eu_pkg::ST_DRAW_WR: begin
				f_addr = y0_q + cnt_q;
				f_we = 1'b1;
				f_wd = nrow;
			end
			c8eu_pkg::ST_CLR_CHK: f_we = 1'b1;
			c8eu_pkg::ST_EMIT, c8eu_pkg::ST_CLR_EMIT: f_addr = rid_q[cnt_q];
			default: ;
		endcase
	end

	assign in_stall = state_q != c8eu_pkg::ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = state_q == c8eu_pkg::ST_CLR_EMIT;

	always_comb begin
		out_data.has_row = rows_q != 6'd0;
		out_data.row_index = rows_q != 6'd0 ? rid_q[cnt_q] : 5'd0;
		out_data.row_pixels = rows_q != 6'd0 ? f_rd : 64'h0;
		out_data.program_counter = pc_q;
		out_data.index_value = i_q;
		out_data.sound_on = st_q != 8'd0;
		out_data.waiting_key = wait_q;
		out_data.error_code = err_q;
		out_data.last = rows_q == 6'd0 || last_row;
	end

	logic [4:0] low_key;
	logic       any_key;
	always_comb begin
		low_key = 5'd0;
		any_key = 1'b0;
		for (int k = 15; k >= 0; k--)
			if (req_q.keys_down[k]) begin
				low_key = 5'(k);
				any_key = 1'b1;
			end
	end

	logic kd;
	assign kd = vx < 8'd16 && req_q.keys_down[vx[3:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c8eu_pkg::ST_FILL;
			fill_q <= '0;
			start_q <= 12'd512;
			pc_q <= 12'd512;
			i_q <= '0;
			sp_q <= '0;
			dt_q <= '0;
			st_q <= '0;
			err_q <= '0;
			wait_q <= 1'b0;
			cnt_q <= '0;
			rows_q <= '0;
			for (int k = 0; k < 16; k++) v_q[k] <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid) start_q <= cfg_data;
			case (state_q)
				c8eu_pkg::ST_FILL: fill_q <= fill_q + FW'(1);
				c8eu_pkg::ST_IDLE: begin
					cnt_q <= '0;
					rows_q <= '0;
					err_q <= c8eu_pkg::ERR_OK;
					wait_q <= 1'b0;
					hit_q <= 1'b0;
				end
				c8eu_pkg::ST_DEC: begin
					x0_q <= vx[5:0];
					y0_q <= vy[4:0];
					if (req_q.kind == c8eu_pkg::KIND_LOAD) pc_q <= start_q;
					else if (req_q.kind == c8eu_pkg::KIND_TICK) begin
						if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
						if (st_q != 8'd0) st_q <= st_q - 8'd1;
					end else if (req_q.kind == c8eu_pkg::KIND_EXEC) begin
						case (op_hi)
							4'h0:
								if (req_q.opcode == 16'h00EE) begin
									if (sp_q == '0) err_q <= c8eu_pkg::ERR_UNDER;
									else begin
										sp_q <= sp_q - DW'(1);
										pc_q <= stk_q[SW'(sp_q - DW'(1))];
									end
								end else if (req_q.opcode != 16'h00E0) err_q <= c8eu_pkg::ERR_UNK;
							4'h1: pc_q <= req_q.opcode[11:0];
							4'h2:
								if (32'(sp_q) >= STACK_ENTRIES) err_q <= c8eu_pkg::ERR_OVER;
								else begin
									stk_q[SW'(sp_q)] <= pc_q;
									sp_q <= sp_q + DW'(1);
									pc_q <= req_q.opcode[11:0];
								end
							4'h3: if (vx == kk) pc_q <= pc_q + 12'd2;
							4'h4: if (vx != kk) pc_q <= pc_q + 12'd2;
							4'h5, 4'h9:
								if (on != 4'd0) err_q <= c8eu_pkg::ERR_UNK;
								else if ((vx == vy) ^ op_hi[3]) pc_q <= pc_q + 12'd2;
							4'h6: v_q[ox] <= kk;
							4'h7: v_q[ox] <= vx + kk;
							4'h8:
								case (on)
									4'h0: v_q[ox] <= vy;
									4'h1: v_q[ox] <= vx | vy;
									4'h2: v_q[ox] <= vx & vy;
									4'h3: v_q[ox] <= vx ^ vy;
									4'h4: begin
										v_q[15] <= {7'd0, 9'(vx) + 9'(vy) > 9'd255};
										v_q[ox] <= vx + vy;
									end
									4'h5: begin
										v_q[15] <= {7'd0, vx > vy};
										v_q[ox] <= vx - vy;
									end
									4'h6: begin
										v_q[15] <= {7'd0, vx[0]};
										v_q[ox] <= vx >> 1;
									end
									4'h7: begin
										v_q[15] <= {7'd0, vy > vx};
										v_q[ox] <= vy - vx;
									end
									4'hE: begin
										v_q[15] <= {7'd0, vx[7]};
										v_q[ox] <= vx << 1;
									end
									default: err_q <= c8eu_pkg::ERR_UNK;
								endcase
							4'hA: i_q <= req_q.opcode[11:0];
							4'hB: pc_q <= req_q.opcode[11:0] + 12'(v_q[0]);
							4'hC: v_q[ox] <= req_q.random_byte & kk;
							4'hD: ;
							4'hE:
								if (kk == 8'h9E) begin
									if (kd) pc_q <= pc_q + 12'd2;
								end else if (kk == 8'hA1) begin
									if (!kd) pc_q <= pc_q + 12'd2;
								end else err_q <= c8eu_pkg::ERR_UNK;
							default:
								case (kk)
									8'h07: v_q[ox] <= dt_q;
									8'h0A:
										if (any_key) v_q[ox] <= 8'(low_key);
										else begin
											pc_q <= pc_q - 12'd2;
											wait_q <= 1'b1;
										end
									8'h15: dt_q <= vx;
									8'h18: st_q <= vx;
									8'h1E: i_q <= i_q + 12'(vx);
									8'h29: i_q <= 12'(vx[3:0]) * 12'(c8eu_pkg::GLYPH_HEIGHT);
									8'h33, 8'h55, 8'h65: ;
									default: err_q <= c8eu_pkg::ERR_UNK;
								endcase
						endcase
					end
				end
				c8eu_pkg::ST_MEM_WR: begin
					if (!blk_store && !is_bcd) v_q[cnt_q[3:0]] <= m_rd;
					cnt_q <= (cnt_q + 5'd1 >= mem_n) ? 5'd0 : cnt_q + 5'd1;
				end
				c8eu_pkg::ST_DRAW_WR: begin
					if ((f_rd & smask) != 64'h0) hit_q <= 1'b1;
					if (nrow != f_rd) begin
						rid_q[rows_q[4:0]] <= y0_q + cnt_q;
						rows_q <= rows_q + 6'd1;
					end
					cnt_q <= cnt_q + 5'd1;
				end
				c8eu_pkg::ST_CLR_CHK: begin
					if (f_rd != 64'h0) begin
						rid_q[rows_q[4:0]] <= cnt_q;
						rows_q <= rows_q + 6'd1;
					end
					cnt_q <= cnt_q + 5'd1;
				end
				c8eu_pkg::ST_FIN: begin
					if (is_draw) v_q[15] <= {7'd0, hit_q};
					cnt_q <= '0;
				end
				c8eu_pkg::ST_CLR_EMIT: if (out_fire) cnt_q <= cnt_q + 5'd1;
				default: ;
			endcase
		end
	end

	// request register, loaded when idle; draw reads memory while framebuffer row is read, same cycle
	always_ff @(posedge clk) begin
		if (state_q == c8eu_pkg::ST_IDLE && in_valid)
			req_q <= in_data;
	end

	property p_busy_stall;
		@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall;
	endproperty
	assert property (p_busy_stall) else $error("request taken while results pending");

	property p_hold;
		@(posedge clk) disable iff (!arst_n)
			out_valid && out_stall |=> out_valid && $stable(out_data);
	endproperty
	assert property (p_hold) else $error("stalled result changed");

	property p_stack;
		@(posedge clk) disable iff (!arst_n) 32'(sp_q) <= STACK_ENTRIES;
	endproperty
	assert property (p_stack) else $error("stack depth out of range");
endmodule
`default_nettype wire
